/* src/htg_pkg.sv */
// ----------------------------------------------------------------------------
// htg_pkg: shared types and constants for host_counter_to_guest_ticks
// Config record, controller command bundle, register indexes, op codes.
// ----------------------------------------------------------------------------
`default_nettype none

package htg_pkg;

   localparam int COUNTER_W  = 64;
   localparam int FREQ_W     = 40;
   localparam int CLOCK_W    = 32;
   localparam int SHIFT_W    = 3;
   localparam int TICKS_W    = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = FREQ_W;

   // delta < 2^63, clock < 2^32, remainder < 2^40: dividend fits in 96 bits
   localparam int DIVIDEND_W = 96;
   localparam int DIV_STEPS  = DIVIDEND_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [FREQ_W-1:0]  FREQ_RESET  = 40'd19200000;
   localparam logic [CLOCK_W-1:0] CLOCK_RESET = 32'd248625000;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd3;

   localparam logic OP_SAMPLE  = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COUNTER_FREQUENCY = 2'd0,
      CSR_GUEST_CLOCK       = 2'd1,
      CSR_SHIFT_FACTOR      = 2'd2
   } htg_csr_type;

   typedef struct packed {
      logic [FREQ_W-1:0]  counter_frequency;
      logic [CLOCK_W-1:0] guest_clock;
      logic [SHIFT_W-1:0] shift_factor;
   } htg_cfg_type;

   typedef struct packed {
      logic load;      // capture request beat, update last counter
      logic mul_lo;    // add delta[31:0] * clock into dividend
      logic mul_hi;    // add delta[63:32] * clock << 32 into dividend
      logic div_step;  // one restoring division step
      logic finish;    // scale and accumulate on a sample, load output register
   } htg_cmd_type;

endpackage

`default_nettype wire

/* src/htg_ctrl.sv */
// ----------------------------------------------------------------------------
// htg_ctrl: sequencing state machine
// Steps the datapath through load, two multiply passes, the division and
// the final accumulate (a restart skips to finish); owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module htg_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_operation,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output htg_pkg::htg_cmd_type      cmd
);
   import htg_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_MUL_LO = 5'b00010,
      ST_MUL_HI = 5'b00100,
      ST_DIVIDE = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_STEPS - 1);

   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      count_in = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = (req_operation == OP_RESTART) ? ST_FINISH : ST_MUL_LO;
            end
         end
         ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            count_in   = '0;
            state_in   = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + 1'b1;
            if (count_ff == LAST_STEP) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free or draining
            if (slot_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_restart_skips: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation == OP_RESTART) |=> state_ff == ST_FINISH)
      else $error("restart beat did not go straight to finish");

   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) && (count_ff == LAST_STEP) |=> state_ff == ST_FINISH)
      else $error("division did not end after the last step");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside finish");

endmodule

`default_nettype wire

/* src/htg_datapath.sv */
// ----------------------------------------------------------------------------
// htg_datapath: delta, multiply, restoring divide, scale and accumulate
// Holds last counter, carried remainder and tick total plus output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module htg_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire htg_pkg::htg_cmd_type             cmd,
   input  wire htg_pkg::htg_cfg_type             cfg,
   input  wire logic                             req_operation,
   input  wire logic [htg_pkg::COUNTER_W-1:0]    req_counter_now,
   output logic [htg_pkg::TICKS_W-1:0]           rsp_guest_ticks,
   output logic [htg_pkg::TICKS_W-1:0]           rsp_elapsed_ticks
);
   import htg_pkg::*;

   logic                    op_ff, op_in;
   logic [COUNTER_W-1:0]    delta_ff, delta_in;
   logic [COUNTER_W-1:0]    last_ff, last_in;
   logic [FREQ_W-1:0]       carry_ff, carry_in;      // remainder, also division work reg
   logic [TICKS_W-1:0]      total_ff, total_in;
   logic [DIVIDEND_W-1:0]   div_ff, div_in;          // dividend, shifts into quotient
   logic [TICKS_W-1:0]      guest_ff, guest_in;
   logic [TICKS_W-1:0]      elapsed_ff, elapsed_in;

   logic [COUNTER_W-1:0]    delta_raw;
   logic [CLOCK_W-1:0]      mul_a;
   logic [2*CLOCK_W-1:0]    product;
   logic [DIVIDEND_W-1:0]   addend;
   logic [FREQ_W:0]         trial, diff;
   logic                    ge;
   logic [TICKS_W-1:0]      quotient, scaled, sum;

   assign delta_raw = req_counter_now - last_ff;

   // one 32x32 multiplier shared by both passes
   assign mul_a   = cmd.mul_hi ? delta_ff[2*CLOCK_W-1:CLOCK_W] : delta_ff[CLOCK_W-1:0];
   assign product = mul_a * cfg.guest_clock;
   assign addend  = cmd.mul_hi ? {product, {CLOCK_W{1'b0}}}
                               : {{(DIVIDEND_W-2*CLOCK_W){1'b0}}, product};

   assign trial = {carry_ff, div_ff[DIVIDEND_W-1]};
   assign ge    = trial >= {1'b0, cfg.counter_frequency};
   assign diff  = trial - {1'b0, cfg.counter_frequency};

   // saturate quotient, drop bits lost by the x8, then shift down
   assign quotient = (|div_ff[DIVIDEND_W-1:TICKS_W]) ? '1 : div_ff[TICKS_W-1:0];
   assign scaled   = {quotient[TICKS_W-4:0], 3'b000} >> cfg.shift_factor;
   assign sum      = total_ff + scaled;

   always_comb begin
      op_in      = op_ff;
      delta_in   = delta_ff;
      last_in    = last_ff;
      carry_in   = carry_ff;
      total_in   = total_ff;
      div_in     = div_ff;
      guest_in   = guest_ff;
      elapsed_in = elapsed_ff;

      if (cmd.load) begin
         op_in = req_operation;
         if (req_operation == OP_RESTART) begin
            last_in  = req_counter_now;
            total_in = '0;
         end else begin
            delta_in = delta_raw[COUNTER_W-1] ? '0 : delta_raw;
            if (req_counter_now > last_ff) begin
               last_in = req_counter_now;
            end
            div_in   = {{(DIVIDEND_W-FREQ_W){1'b0}}, carry_ff};
            carry_in = '0;
         end
      end

      if (cmd.mul_lo || cmd.mul_hi) begin
         div_in = div_ff + addend;
      end

      if (cmd.div_step) begin
         carry_in = ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
         div_in   = {div_ff[DIVIDEND_W-2:0], ge};
      end

      if (cmd.finish) begin
         if (op_ff == OP_RESTART) begin
            guest_in   = total_ff;
            elapsed_in = '0;
         end else begin
            total_in   = sum;
            guest_in   = sum;
            elapsed_in = scaled;
            if (cfg.counter_frequency == '0) begin
               carry_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= '0;
         carry_ff <= '0;
         total_ff <= '0;
      end else begin
         last_ff  <= last_in;
         carry_ff <= carry_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      delta_ff   <= delta_in;
      div_ff     <= div_in;
      guest_ff   <= guest_in;
      elapsed_ff <= elapsed_in;
   end

   assign rsp_guest_ticks   = guest_ff;
   assign rsp_elapsed_ticks = elapsed_ff;

   a_rem_seeded: assert property (@(posedge clock) disable iff (reset)
      cmd.load && (req_operation == OP_SAMPLE) |=> carry_ff == '0)
      else $error("work remainder not cleared after seeding dividend");

   a_restart_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && (op_ff == OP_RESTART) |=> (elapsed_ff == '0) && (guest_ff == '0))
      else $error("restart beat reported nonzero ticks");

   a_zero_freq: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && (op_ff == OP_SAMPLE) && (cfg.counter_frequency == '0)
      |=> carry_ff == '0)
      else $error("remainder kept with zero frequency");

endmodule

`default_nettype wire

/* src/host_counter_to_guest_ticks.sv */
// ----------------------------------------------------------------------------
// host_counter_to_guest_ticks: drift-free host counter to guest tick converter
// Keeps last counter, carried remainder and a running 64-bit tick total.
// ----------------------------------------------------------------------------
// Usage:
//   req_* beat: operation 0 samples counter_now and adds the scaled guest
//   ticks since the last sample; operation 1 restarts the total at
//   counter_now. Each request beat produces exactly one rsp_* beat.
//   csr_* beat: writes counter_frequency (0), guest_clock (1) or
//   shift_factor (2); csr_ready is always high. Write only when idle.
// Sequence:
//   A sample beat runs load, two 32x32 multiply passes and a 96-step
//   restoring division (one quotient bit per cycle), then the finish state,
//   which waits while an older response is still held: rsp_valid rises as
//   finish ends, and req_ready returns in the same cycle. Restart beats go
//   from load straight to finish. A new request is taken only when idle.
// Reset: synchronous; last counter, remainder and total clear to zero,
//   registers take their default values, no beat is pending.
// Stall: the result sits in the output register while the next request
//   is accepted and processed; a newer result waits in the finish state
//   until the older one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module host_counter_to_guest_ticks (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_operation,
   input  wire logic [htg_pkg::COUNTER_W-1:0]     req_counter_now,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [htg_pkg::TICKS_W-1:0]            rsp_guest_ticks,
   output logic [htg_pkg::TICKS_W-1:0]            rsp_elapsed_ticks,
   // register write channel
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [htg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [htg_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import htg_pkg::*;

   htg_cfg_type cfg_ff, cfg_in;
   htg_cmd_type cmd;

   assign csr_ready = 1'b1;

   // register file; an index past the list is dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_COUNTER_FREQUENCY: cfg_in.counter_frequency = csr_wdata[FREQ_W-1:0];
            CSR_GUEST_CLOCK:       cfg_in.guest_clock       = csr_wdata[CLOCK_W-1:0];
            CSR_SHIFT_FACTOR:      cfg_in.shift_factor      = csr_wdata[SHIFT_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.counter_frequency <= FREQ_RESET;
         cfg_ff.guest_clock       <= CLOCK_RESET;
         cfg_ff.shift_factor      <= SHIFT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   htg_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .cmd           (cmd)
   );

   htg_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .cfg               (cfg_ff),
      .req_operation     (req_operation),
      .req_counter_now   (req_counter_now),
      .rsp_guest_ticks   (rsp_guest_ticks),
      .rsp_elapsed_ticks (rsp_elapsed_ticks)
   );

endmodule

`default_nettype wire
